/* hw/rtl/hsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and helpers of the Huffman stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int MAX_NODES   = 512;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int IDX_W       = 9;
    localparam int SYMBOL_BITS = 8;
    localparam int SYM_W       = 8;
    localparam int BYTE_BITS   = 8;
    localparam int NBITS_W     = 4;

    localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << SYMBOL_BITS) - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_ROOT = 1'b0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_MISSING = 1'b1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             has_left;
        logic             has_right;
        logic [SYM_W-1:0] symbol;
    } node_t;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   index;
        node_t              node;
        logic [BYTE_BITS-1:0] code;
        logic [NBITS_W-1:0] nbits;
    } qitem_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(MAX_NODES);
    endfunction

endpackage

/* hw/rtl/hsd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_front
// Accepts input words, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module hsd_front (
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            cmd,
    input  logic [hsd_pkg::IDX_W-1:0]       node_index,
    input  logic [hsd_pkg::IDX_W-1:0]       left_child,
    input  logic [hsd_pkg::IDX_W-1:0]       right_child,
    input  logic                            has_left,
    input  logic                            has_right,
    input  logic [hsd_pkg::SYM_W-1:0]       node_symbol,
    input  logic [hsd_pkg::BYTE_BITS-1:0]   code_byte,
    input  logic [hsd_pkg::NBITS_W-1:0]     valid_bits,
    input  logic                            q_full,
    output logic                            q_push,
    output hsd_pkg::qitem_t                 q_item
);

    logic accept;
    logic keep;
    logic [hsd_pkg::NBITS_W-1:0] nbits_sat;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    // saturate the bit count to one byte
    assign nbits_sat = (valid_bits > hsd_pkg::NBITS_W'(hsd_pkg::BYTE_BITS))
                       ? hsd_pkg::NBITS_W'(hsd_pkg::BYTE_BITS) : valid_bits;

    always_comb
    begin
        q_item.op             = hsd_pkg::op_t'(cmd);
        q_item.index          = node_index;
        q_item.node.left      = left_child;
        q_item.node.right     = right_child;
        q_item.node.has_left  = has_left;
        q_item.node.has_right = has_right;
        q_item.node.symbol    = node_symbol & hsd_pkg::SYM_MASK;
        q_item.code           = code_byte;
        q_item.nbits          = nbits_sat;
        unique case (hsd_pkg::op_t'(cmd))
            hsd_pkg::OP_WRITE:  keep = hsd_pkg::idx_ok(node_index);
            hsd_pkg::OP_DECODE: keep = (nbits_sat != '0);
            default:            keep = 1'b0;
        endcase
    end

    assign q_push = accept && keep;

endmodule

/* hw/rtl/hsd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module hsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsd_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output hsd_pkg::qitem_t head_item
);

    hsd_pkg::qitem_t entry_reg [hsd_pkg::QUEUE_DEPTH];
    logic [hsd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [hsd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [hsd_pkg::QCNT_W-1:0] count_reg;

    assign full       = (count_reg == hsd_pkg::QCNT_W'(hsd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/hsd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_back
// Node table and tree walk: writes nodes, walks code bits, emits symbols.
// ----------------------------------------------------------------------------
module hsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  hsd_pkg::qitem_t             q_item,
    output logic                        q_pop,
    input  logic [hsd_pkg::IDX_W-1:0]   root,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [hsd_pkg::SYM_W-1:0]   symbol,
    output logic                        status,
    output logic                        last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_CHECK,
        ST_END
    } state_t;

    state_t state_reg;

    hsd_pkg::node_t node_mem [hsd_pkg::MAX_NODES];
    hsd_pkg::node_t rd_data_reg;

    logic [hsd_pkg::IDX_W-1:0]     walk_reg;
    logic                          cur_ok_reg;
    logic                          cur_empty_reg;
    logic [hsd_pkg::BYTE_BITS-1:0] code_reg;
    logic [hsd_pkg::NBITS_W-1:0]   count_reg;

    logic                          pend_valid_reg;
    logic [hsd_pkg::SYM_W-1:0]     pend_symbol_reg;
    logic                          pend_status_reg;

    logic                          out_valid_reg;
    logic [hsd_pkg::SYM_W-1:0]     out_symbol_reg;
    logic                          out_status_reg;
    logic                          out_last_reg;

    hsd_pkg::node_t                cur;
    logic                          bit_one;
    logic                          child_exists;
    logic [hsd_pkg::IDX_W-1:0]     child_idx;
    logic                          missing;
    logic                          leaf;
    logic                          out_free;
    logic                          can_insert;
    logic                          mem_we;
    logic                          mem_re;
    logic [hsd_pkg::IDX_W-1:0]     mem_raddr;

    assign cur          = cur_empty_reg ? hsd_pkg::node_t'('0) : rd_data_reg;
    assign bit_one      = code_reg[hsd_pkg::BYTE_BITS-1];
    assign child_exists = bit_one ? cur.has_right : cur.has_left;
    assign child_idx    = bit_one ? cur.right : cur.left;
    assign missing      = !child_exists || !hsd_pkg::idx_ok(child_idx);
    assign leaf         = !rd_data_reg.has_left && !rd_data_reg.has_right;
    assign out_free     = !out_valid_reg || !result_stall;
    assign can_insert   = !pend_valid_reg || out_free;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.op == hsd_pkg::OP_WRITE);
    assign mem_re    = (state_reg == ST_FETCH) || ((state_reg == ST_EVAL) && !missing);
    assign mem_raddr = (state_reg == ST_FETCH) ? walk_reg : child_idx;

    assign result_valid = out_valid_reg;
    assign symbol       = out_symbol_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

    // node table, single port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[hsd_pkg::NODE_AW'(q_item.index)] <= q_item.node;
        end
        else if (mem_re)
        begin
            rd_data_reg <= node_mem[hsd_pkg::NODE_AW'(mem_raddr)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_reg       <= '0;
            cur_ok_reg     <= 1'b0;
            cur_empty_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.op == hsd_pkg::OP_WRITE)
                        begin
                            cur_ok_reg <= 1'b0;
                        end
                        else
                        begin
                            code_reg  <= q_item.code;
                            count_reg <= q_item.nbits;
                            state_reg <= cur_ok_reg ? ST_EVAL : ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    cur_empty_reg <= !hsd_pkg::idx_ok(walk_reg);
                    cur_ok_reg    <= 1'b1;
                    state_reg     <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (missing)
                    begin
                        if (can_insert)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_symbol_reg <= pend_symbol_reg;
                                out_status_reg <= pend_status_reg;
                                out_last_reg   <= 1'b0;
                            end
                            pend_valid_reg  <= 1'b1;
                            pend_symbol_reg <= '0;
                            pend_status_reg <= hsd_pkg::STATUS_MISSING;
                            walk_reg        <= root;
                            cur_ok_reg      <= 1'b0;
                            state_reg       <= ST_END;
                        end
                    end
                    else
                    begin
                        walk_reg      <= child_idx;
                        cur_empty_reg <= 1'b0;
                        code_reg      <= {code_reg[hsd_pkg::BYTE_BITS-2:0], 1'b0};
                        count_reg     <= count_reg - 1'b1;
                        state_reg     <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (leaf)
                    begin
                        if (can_insert)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_symbol_reg <= pend_symbol_reg;
                                out_status_reg <= pend_status_reg;
                                out_last_reg   <= 1'b0;
                            end
                            pend_valid_reg  <= 1'b1;
                            pend_symbol_reg <= rd_data_reg.symbol;
                            pend_status_reg <= hsd_pkg::STATUS_OK;
                            walk_reg        <= root;
                            cur_ok_reg      <= 1'b0;
                            state_reg       <= (count_reg == '0) ? ST_END : ST_FETCH;
                        end
                    end
                    else
                    begin
                        cur_ok_reg <= 1'b1;
                        state_reg  <= (count_reg == '0) ? ST_END : ST_EVAL;
                    end
                end
                ST_END:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_symbol_reg <= pend_symbol_reg;
                        out_status_reg <= pend_status_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/huffman_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Huffman tree-walk decoder over a node table loaded through the item port.
// ----------------------------------------------------------------------------
// A node write is done in ST_IDLE as it is popped from the queue. Each valid
// bit of a decode word passes through ST_EVAL and ST_CHECK as the walk goes
// down the tree; the root is fetched again in ST_FETCH after each symbol
// found, and a word starts in ST_IDLE and ends in ST_END. The pace is set
// by the single-port node table: every bit needs a read of the child node
// before the next bit can be taken. The input queue keeps accepting words,
// until full, while a decode runs; a result waits in an output register.
// ----------------------------------------------------------------------------
module huffman_stream_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [hsd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [hsd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                cmd,
    input  logic [hsd_pkg::IDX_W-1:0]           node_index,
    input  logic [hsd_pkg::IDX_W-1:0]           left_child,
    input  logic [hsd_pkg::IDX_W-1:0]           right_child,
    input  logic                                has_left,
    input  logic                                has_right,
    input  logic [hsd_pkg::SYM_W-1:0]           node_symbol,
    input  logic [hsd_pkg::BYTE_BITS-1:0]       code_byte,
    input  logic [hsd_pkg::NBITS_W-1:0]         valid_bits,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [hsd_pkg::SYM_W-1:0]           symbol,
    output logic                                status,
    output logic                                last
);

    logic [hsd_pkg::IDX_W-1:0] root_reg;
    logic                      cfg_write;

    logic            q_full;
    logic            q_push;
    hsd_pkg::qitem_t q_push_item;
    logic            q_pop;
    logic            q_valid;
    hsd_pkg::qitem_t q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[hsd_pkg::CFG_ADDR_W-1] == hsd_pkg::REG_ROOT);
    assign prdata    = (paddr[hsd_pkg::CFG_ADDR_W-1] == hsd_pkg::REG_ROOT)
                       ? hsd_pkg::CFG_DATA_W'(root_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg_write)
        begin
            root_reg <= pwdata[hsd_pkg::IDX_W-1:0];
        end
    end

    hsd_front u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .cmd         (cmd),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .has_left    (has_left),
        .has_right   (has_right),
        .node_symbol (node_symbol),
        .code_byte   (code_byte),
        .valid_bits  (valid_bits),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    hsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    hsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_head),
        .q_pop        (q_pop),
        .root         (root_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .status       (status),
        .last         (last)
    );

endmodule

/* test/huffman_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_stream_checker
// Watches the item, result and register ports of the Huffman stream decoder.
// Every accepted decode word is walked through a private copy of the node
// table and walk position. The expected words are queued, and each accepted
// result is compared field by field with the oldest one. Register writes
// move the private root, and register reads are checked against it.
// ----------------------------------------------------------------------------
module huffman_stream_checker
    import hsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    input  logic [CFG_DATA_W-1:0]   prdata,
    input  logic                    pready,
    input  logic                    item_valid,
    input  logic                    item_stall,
    input  logic                    cmd,
    input  logic [IDX_W-1:0]        node_index,
    input  logic [IDX_W-1:0]        left_child,
    input  logic [IDX_W-1:0]        right_child,
    input  logic                    has_left,
    input  logic                    has_right,
    input  logic [SYM_W-1:0]        node_symbol,
    input  logic [BYTE_BITS-1:0]    code_byte,
    input  logic [NBITS_W-1:0]      valid_bits,
    input  logic                    result_valid,
    input  logic                    result_stall,
    input  logic [SYM_W-1:0]        symbol,
    input  logic                    status,
    input  logic                    last,
    output int                      fail_count,
    output int                      pending,
    output int                      result_count,
    output int                      error_count
);

    localparam logic [CFG_ADDR_W-1:0] ROOT_ADDR = CFG_ADDR_W'(4 * int'(REG_ROOT));
    localparam int REPORT_CAP = 25;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
        logic             last;
    } decoded_t;

    node_t            tree_mem [MAX_NODES];
    logic [IDX_W-1:0] walk_node;
    logic [IDX_W-1:0] root_index;
    decoded_t         expected_words [$];

    task automatic flag_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic walk_byte(input logic [BYTE_BITS-1:0] code, input logic [NBITS_W-1:0] nbits);
        int               steps;
        logic             one;
        logic             found;
        logic [IDX_W-1:0] next_node;
        node_t            here;
        decoded_t         hit;
        decoded_t         found_words [$];
        steps = (int'(nbits) > BYTE_BITS) ? BYTE_BITS : int'(nbits);
        for (int i = 0; i < steps; i++)
        begin
            here = tree_mem[walk_node];
            one = code[BYTE_BITS-1-i];
            found = one ? here.has_right : here.has_left;
            next_node = one ? here.right : here.left;
            if (!found || int'(next_node) >= MAX_NODES)
            begin
                hit.symbol = '0;
                hit.status = STATUS_MISSING;
                hit.last = 1'b0;
                found_words = {found_words, hit};
                walk_node = root_index;
                break;
            end
            walk_node = next_node;
            here = tree_mem[next_node];
            if (!here.has_left && !here.has_right)
            begin
                hit.symbol = here.symbol & SYM_MASK;
                hit.status = STATUS_OK;
                hit.last = 1'b0;
                found_words = {found_words, hit};
                walk_node = root_index;
            end
        end
        foreach (found_words[k])
        begin
            hit = found_words[k];
            hit.last = (k == found_words.size() - 1);
            expected_words = {expected_words, hit};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        node_t    entry;
        if (!rst_n)
        begin
            walk_node = '0;
            root_index = '0;
            expected_words.delete();
            fail_count = 0;
            pending = 0;
            result_count = 0;
            error_count = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ROOT_ADDR)
            begin
                if (pwrite)
                    root_index = pwdata[IDX_W-1:0];
                else if (prdata !== CFG_DATA_W'(root_index))
                    flag_mismatch("root readback", int'(root_index), int'(prdata));
            end

            if (result_valid && !result_stall)
            begin
                result_count++;
                if (status === STATUS_MISSING)
                    error_count++;
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display({"%0t: unexpected word, expected none, ",
                                  "actual symbol %0d status %0d last %0d"},
                                 $time, symbol, status, last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (symbol !== want.symbol)
                        flag_mismatch("symbol", int'(want.symbol), int'(symbol));
                    if (status !== want.status)
                        flag_mismatch("status", int'(want.status), int'(status));
                    if (last !== want.last)
                        flag_mismatch("last", int'(want.last), int'(last));
                end
            end

            if (item_valid && !item_stall)
            begin
                if (op_t'(cmd) == OP_WRITE)
                begin
                    if (int'(node_index) < MAX_NODES)
                    begin
                        entry.left = left_child;
                        entry.right = right_child;
                        entry.has_left = has_left;
                        entry.has_right = has_right;
                        entry.symbol = node_symbol & SYM_MASK;
                        tree_mem[node_index] = entry;
                    end
                end
                else
                    walk_byte(code_byte, valid_bits);
            end

            pending = expected_words.size();
        end
    end

endmodule

/* test/tb_huffman_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_stream_decoder
// Stimulus and verdict for the Huffman stream decoder. A short directed run
// covers leaf roots, full and saturated bytes, empty bytes, missing children
// and a root change in the middle of a walk. Random phases then build fresh
// trees, point the root at them and feed coded bytes with a few stray node
// rewrites. Both ports idle at random, and the receiver holds off once for a
// long stretch. A side checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_huffman_stream_decoder;
    import hsd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 128;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 480;
    localparam logic [CFG_ADDR_W-1:0] ROOT_ADDR = CFG_ADDR_W'(4 * int'(REG_ROOT));

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   item_valid;
    logic                   item_stall;
    logic                   cmd;
    logic [IDX_W-1:0]       node_index;
    logic [IDX_W-1:0]       left_child;
    logic [IDX_W-1:0]       right_child;
    logic                   has_left;
    logic                   has_right;
    logic [SYM_W-1:0]       node_symbol;
    logic [BYTE_BITS-1:0]   code_byte;
    logic [NBITS_W-1:0]     valid_bits;
    logic                   result_valid;
    logic                   result_stall;
    logic [SYM_W-1:0]       symbol;
    logic                   status;
    logic                   last;

    int fail_count;
    int pending;
    int result_count;
    int error_count;

    int  words_sent;
    int  node_writes;
    int  decode_bytes;
    int  root_settings;
    int  hold_asked;
    int  hold_served;
    int  quiet_cycles;
    bit  steady_feed;
    bit  node_known [MAX_NODES];
    int  known_nodes [$];

    huffman_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .node_index   (node_index),
        .left_child   (left_child),
        .right_child  (right_child),
        .has_left     (has_left),
        .has_right    (has_right),
        .node_symbol  (node_symbol),
        .code_byte    (code_byte),
        .valid_bits   (valid_bits),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .status       (status),
        .last         (last)
    );

    huffman_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .node_index   (node_index),
        .left_child   (left_child),
        .right_child  (right_child),
        .has_left     (has_left),
        .has_right    (has_right),
        .node_symbol  (node_symbol),
        .code_byte    (code_byte),
        .valid_bits   (valid_bits),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .status       (status),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .error_count  (error_count)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [IDX_W-1:0] pick_known();
        return IDX_W'(known_nodes[$urandom_range(0, known_nodes.size() - 1)]);
    endfunction

    task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
                             input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
                             input logic hl, input logic hr, input logic [SYM_W-1:0] sym,
                             input logic [BYTE_BITS-1:0] code, input logic [NBITS_W-1:0] nbits);
        int gap;
        gap = steady_feed ? 0 : idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= op;
        node_index  <= idx;
        left_child  <= l;
        right_child <= r;
        has_left    <= hl;
        has_right   <= hr;
        node_symbol <= sym;
        code_byte   <= code;
        valid_bits  <= nbits;
        do @(posedge clk); while (item_stall);
        words_sent++;
        if (op == OP_WRITE)
            node_writes++;
        else
            decode_bytes++;
    endtask

    task automatic put_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] l,
                            input logic [IDX_W-1:0] r, input logic hl, input logic hr,
                            input logic [SYM_W-1:0] sym);
        if (!node_known[idx])
        begin
            node_known[idx] = 1'b1;
            known_nodes = {known_nodes, int'(idx)};
        end
        send_word(OP_WRITE, idx, l, r, hl, hr, sym,
                  BYTE_BITS'($urandom()), NBITS_W'($urandom()));
    endtask

    task automatic feed_byte(input logic [BYTE_BITS-1:0] code, input logic [NBITS_W-1:0] nbits);
        send_word(OP_DECODE, IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
                  1'($urandom()), 1'($urandom()), SYM_W'($urandom()), code, nbits);
    endtask

    // rewrite one node, existing children only ever point at written nodes
    task automatic tweak_node();
        logic hl;
        logic hr;
        hl = 1'($urandom());
        hr = 1'($urandom());
        put_node(IDX_W'($urandom()), hl ? pick_known() : IDX_W'($urandom()),
                 hr ? pick_known() : IDX_W'($urandom()), hl, hr, SYM_W'($urandom()));
    endtask

    // leaves first, then parents over subtrees already written
    task automatic grow_tree(input int leaves, output logic [IDX_W-1:0] tree_root);
        int heads [$];
        bit taken [MAX_NODES];
        int idx;
        int pos;
        int a;
        int b;
        for (int k = 0; k < leaves; k++)
        begin
            do idx = $urandom_range(0, MAX_NODES - 1); while (taken[idx]);
            taken[idx] = 1'b1;
            put_node(IDX_W'(idx), IDX_W'($urandom()), IDX_W'($urandom()), 1'b0, 1'b0,
                     SYM_W'($urandom()));
            heads = {heads, idx};
        end
        while (heads.size() > 1)
        begin
            pos = $urandom_range(0, heads.size() - 1);
            a = heads[pos];
            heads.delete(pos);
            do idx = $urandom_range(0, MAX_NODES - 1); while (taken[idx]);
            taken[idx] = 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                    put_node(IDX_W'(idx), IDX_W'(a), IDX_W'($urandom()), 1'b1, 1'b0,
                             SYM_W'($urandom()));
                else
                    put_node(IDX_W'(idx), IDX_W'($urandom()), IDX_W'(a), 1'b0, 1'b1,
                             SYM_W'($urandom()));
            end
            else
            begin
                pos = $urandom_range(0, heads.size() - 1);
                b = heads[pos];
                heads.delete(pos);
                put_node(IDX_W'(idx), IDX_W'(a), IDX_W'(b), 1'b1, 1'b1, SYM_W'($urandom()));
            end
            heads = {heads, idx};
        end
        tree_root = IDX_W'(heads[0]);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        root_settings++;
    endtask

    task automatic reg_read(input logic [CFG_ADDR_W-1:0] addr);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stall_gen
        int open_run;
        int shut_run;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_served != hold_asked)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
            begin
                open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 12);
                shut_run = 1 + idle_gap();
                result_stall <= 1'b0;
                repeat (open_run) @(posedge clk);
                result_stall <= 1'b1;
                repeat (shut_run) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [IDX_W-1:0] tree_root;
        int               leaves;
        int               run;
        int               pick;
        int               phase;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        item_valid  <= 1'b0;
        cmd         <= 1'b0;
        node_index  <= '0;
        left_child  <= '0;
        right_child <= '0;
        has_left    <= 1'b0;
        has_right   <= 1'b0;
        node_symbol <= '0;
        code_byte   <= '0;
        valid_bits  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leaf root: first bit of any byte is an error
        put_node(9'd511, 9'd0, 9'd511, 1'b0, 1'b0, 8'hFF);
        put_node(9'd0, 9'd511, 9'd0, 1'b0, 1'b0, 8'h00);
        feed_byte(8'hA5, 4'd8);
        // two-leaf tree: eight symbols per byte, saturated and empty counts
        put_node(9'd3, 9'd511, 9'd511, 1'b0, 1'b0, 8'h5A);
        put_node(9'd0, 9'd511, 9'd3, 1'b1, 1'b1, 8'h81);
        feed_byte(8'h00, 4'd8);
        feed_byte(8'hFF, 4'd15);
        feed_byte(8'hFF, 4'd0);
        feed_byte(8'h40, 4'd1);
        // deeper tree with a missing right child under node 4
        put_node(9'd2, 9'd3, 9'd511, 1'b1, 1'b1, 8'h00);
        put_node(9'd4, 9'd2, 9'd0, 1'b1, 1'b0, 8'h11);
        put_node(9'd0, 9'd2, 9'd4, 1'b1, 1'b1, 8'h7E);
        feed_byte(8'h00, 4'd1);
        // root moves while the walk sits at node 2
        settle();
        reg_write(ROOT_ADDR, 32'hFFFF_FFFF);
        reg_read(ROOT_ADDR);
        feed_byte(8'h80, 4'd2);
        settle();
        reg_write(ROOT_ADDR, 32'h0);
        reg_read(ROOT_ADDR);
        feed_byte(8'hC0, 4'd2);
        feed_byte(8'h9B, 4'd8);
        feed_byte(8'h55, 4'd9);

        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            steady_feed = (phase % 4 == 2);
            leaves = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(2, 8);
            grow_tree(leaves, tree_root);
            settle();
            reg_write(ROOT_ADDR, ($urandom() & 32'hFFFF_FE00) | CFG_DATA_W'(tree_root));
            if ($urandom_range(0, 2) == 0)
                reg_read(ROOT_ADDR);
            if (phase == 1)
                hold_asked++;
            run = $urandom_range(15, 40);
            repeat (run)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    tweak_node();
                else if (pick == 1)
                    feed_byte(BYTE_BITS'($urandom()), NBITS_W'($urandom_range(0, 15)));
                else if (pick < 5)
                    feed_byte(BYTE_BITS'($urandom()), NBITS_W'($urandom_range(1, 7)));
                else
                    feed_byte(BYTE_BITS'($urandom()), NBITS_W'(BYTE_BITS));
            end
            phase++;
        end
        steady_feed = 1'b0;
        settle();

        $display("run covered %0d input words: %0d node writes, %0d coded bytes, %0d root writes",
                 words_sent, node_writes, decode_bytes, root_settings);
        $display("%0d output words checked, %0d of them missing-child errors",
                 result_count, error_count);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
